### design/ppisl_pkg.sv
// ----------------------------------------------------------------------------
// ppisl_pkg
// Shared types and constants for the PPI port and sound latch handshake block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppisl_pkg;

  localparam int CmdW      = 2;
  localparam int InDataW   = 40;
  localparam int OutDataW  = 24;

  typedef enum logic [CmdW-1:0] {
    CMD_PORT_READ  = 2'd0,
    CMD_PORT_WRITE = 2'd1,
    CMD_LATCH_READ = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_DIP_A = 1'b0,
    REG_DIP_B = 1'b1
  } cfg_reg_e;

  localparam logic [4:0] PORT_P1      = 5'h00;
  localparam logic [4:0] PORT_P2      = 5'h04;
  localparam logic [4:0] PORT_SYS     = 5'h08;
  localparam logic [4:0] PORT_DIPA_0  = 5'h0c;
  localparam logic [4:0] PORT_DIPB_0  = 5'h0d;
  localparam logic [4:0] PORT_DIPA_1  = 5'h0e;
  localparam logic [4:0] PORT_DIPB_1  = 5'h0f;
  localparam logic [4:0] PORT_DIPB_2  = 5'h10;
  localparam logic [4:0] PORT_DIPB_3  = 5'h11;
  localparam logic [4:0] PORT_DIPB_4  = 5'h12;
  localparam logic [4:0] PORT_DIPB_5  = 5'h13;
  localparam logic [4:0] PORT_A       = 5'h14;
  localparam logic [4:0] PORT_B       = 5'h15;
  localparam logic [4:0] PORT_C       = 5'h16;
  localparam logic [4:0] PORT_CTRL    = 5'h17;

  localparam logic [7:0] PC_HI_MASK   = 8'hc0;
  localparam logic [7:0] PC_LO_MASK   = 8'h3f;
  localparam logic [7:0] BYTE_IDLE    = 8'hff;
  localparam logic [2:0] BSR_LAST_BIT = 3'd5;

  typedef struct packed {
    logic [7:0] sound_latch;
    logic [7:0] port_c;
    logic [7:0] disp_mode;
    logic       nmi_mask;
  } ppi_state_t;

  typedef struct packed {
    logic [7:0] disp_mode_out;
    logic [1:0] vram_bank;
    logic       flip;
    logic [1:0] rom_bank;
    logic       nmi_pulse;
    logic [7:0] rdata;
  } result_t;

  typedef struct packed {
    logic [7:0] system_inputs;
    logic [7:0] player_two;
    logic [7:0] player_one;
    logic [7:0] wdata;
    logic [7:0] port;
  } access_t;

endpackage

### design/ppisl_decode.sv
// ----------------------------------------------------------------------------
// ppisl_decode
// Port decode, PPI latch update and result formation for one bus access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppisl_decode (
  input  logic [ppisl_pkg::CmdW-1:0] cmd_i,
  input  ppisl_pkg::access_t         acc_i,
  input  logic [7:0]                 dip_a_i,
  input  logic [7:0]                 dip_b_i,
  input  ppisl_pkg::ppi_state_t      state_i,
  output ppisl_pkg::ppi_state_t      state_o,
  output ppisl_pkg::result_t         result_o
);
  import ppisl_pkg::*;

  logic [4:0] port_lo;
  logic [7:0] pc_new;
  logic       pc_load;
  logic [7:0] rdata;
  logic       pulse;
  logic [2:0] bsr_bit;

  assign port_lo = acc_i.port[4:0];
  assign bsr_bit = acc_i.wdata[3:1];

  always_comb begin
    state_o = state_i;
    pc_new  = state_i.port_c;
    pc_load = 1'b0;
    rdata   = BYTE_IDLE;
    case (cmd_e'(cmd_i))
      CMD_PORT_READ: begin
        case (port_lo)
          PORT_P1:     rdata = ~acc_i.player_one;
          PORT_P2:     rdata = ~acc_i.player_two;
          PORT_SYS:    rdata = ~acc_i.system_inputs;
          PORT_DIPA_0,
          PORT_DIPA_1: rdata = dip_a_i;
          PORT_DIPB_0,
          PORT_DIPB_1,
          PORT_DIPB_2,
          PORT_DIPB_3,
          PORT_DIPB_4,
          PORT_DIPB_5: rdata = dip_b_i;
          PORT_A:      rdata = state_i.sound_latch;
          PORT_B:      rdata = state_i.disp_mode;
          PORT_C:      rdata = state_i.port_c;
          default:     rdata = BYTE_IDLE;
        endcase
      end
      CMD_PORT_WRITE: begin
        case (port_lo)
          PORT_A: begin
            state_o.sound_latch = acc_i.wdata;
            pc_new  = state_i.port_c & PC_LO_MASK;
            pc_load = 1'b1;
          end
          PORT_B: begin
            state_o.disp_mode = acc_i.wdata;
          end
          PORT_C: begin
            pc_new  = (state_i.port_c & PC_HI_MASK) | (acc_i.wdata & PC_LO_MASK);
            pc_load = 1'b1;
          end
          PORT_CTRL: begin
            if (!acc_i.wdata[7] && (bsr_bit <= BSR_LAST_BIT)) begin
              pc_new[bsr_bit] = acc_i.wdata[0];
              pc_load         = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_LATCH_READ: begin
        pc_new  = state_i.port_c | PC_HI_MASK;
        pc_load = 1'b1;
        rdata   = state_i.sound_latch;
      end
      default: begin
      end
    endcase
    if (pc_load) begin
      state_o.port_c   = pc_new;
      state_o.nmi_mask = pc_new[7];
    end
  end

  assign pulse = pc_load & state_i.nmi_mask & ~pc_new[7];

  always_comb begin
    result_o.rdata         = rdata;
    result_o.nmi_pulse     = pulse;
    result_o.rom_bank      = state_o.disp_mode[3:2];
    result_o.flip          = state_o.disp_mode[7];
    result_o.vram_bank     = state_o.port_c[2:1];
    result_o.disp_mode_out = state_o.disp_mode;
  end

endmodule

### design/ppi_port_and_sound_latch_handshake.sv
// ----------------------------------------------------------------------------
// ppi_port_and_sound_latch_handshake
// Arcade I/O decoder with 8255 PPI latches and sound command latch.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tuser: cmd; tdata: port, wdata, player_one, player_two,
//                      system_inputs
// m_axis    out        tdata: rdata, nmi_pulse, rom_bank, flip, vram_bank,
//                      disp_mode_out
// cfg       in         cfg_index_i: register, cfg_data_i: value (dip_a, dip_b)
//
// One access per cycle unless m_axis stalls; results appear in the next cycle.
// Latches update at the input transfer; the result register holds the answer.
// s_axis_tready_o stays high while the result register is empty or drains.
// Reset loads port C with 0xc0, clears latch and display mode, DIPs to 0xff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppi_port_and_sound_latch_handshake (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // port, wdata, player_one, player_two, system_inputs
  input  logic [ppisl_pkg::InDataW-1:0]  s_axis_tdata_i,
  // cmd
  input  logic [ppisl_pkg::CmdW-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // rdata, nmi_pulse, rom_bank, flip, vram_bank, disp_mode_out, zero pad
  output logic [ppisl_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import ppisl_pkg::*;

  ppi_state_t state_q, state_d;
  result_t    result_d, result_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] dip_a_q, dip_b_q;
  logic       s_fire;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  ppisl_decode u_decode (
    .cmd_i    (s_axis_tuser_i),
    .acc_i    (access_t'(s_axis_tdata_i)),
    .dip_a_i  (dip_a_q),
    .dip_b_i  (dip_b_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.sound_latch <= 8'h00;
      state_q.port_c      <= PC_HI_MASK;
      state_q.disp_mode   <= 8'h00;
      state_q.nmi_mask    <= 1'b1;
      out_valid_q         <= 1'b0;
      dip_a_q             <= BYTE_IDLE;
      dip_b_q             <= BYTE_IDLE;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_fire) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DIP_A: dip_a_q <= cfg_data_i;
          REG_DIP_B: dip_b_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(result_t)){1'b0}}, result_q};

endmodule

### design/ppisl_checker.sv
// ----------------------------------------------------------------------------
// ppisl_checker
// Port-level checks for the PPI port and sound latch handshake block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppisl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [ppisl_pkg::CmdW-1:0]     s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [ppisl_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ppisl_pkg::*;

  logic s_fire;
  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid_o)
    else $error("transfer produced no result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  a_latch_read_no_nmi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser_i == CMD_LATCH_READ) |=> !m_axis_tdata_o[8])
    else $error("latch read pulsed NMI");

  a_bank_from_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[10:9] == m_axis_tdata_o[17:16]) &&
                        (m_axis_tdata_o[11] == m_axis_tdata_o[21]))
    else $error("rom bank or flip disagrees with display mode");

endmodule

bind ppi_port_and_sound_latch_handshake ppisl_checker u_ppisl_checker (.*);
